### design/decimal_string_to_u64_top_assert.svh
// Assertion macros shared by the converter modules.
// Each macro takes a label, the clock, the active-low reset and two expressions.
`ifndef DECIMAL_STRING_TO_U64_TOP_ASSERT_SVH
`define DECIMAL_STRING_TO_U64_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define DSU_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DSU_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define DSU_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define DSU_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

### design/dsu_pkg.sv
package dsu_pkg;

  localparam int VALUE_W = 64;
  localparam int CH_W    = 8;
  localparam int DIGIT_W = 4;

  localparam logic [VALUE_W-1:0] ALL_ONES  = {VALUE_W{1'b1}};
  // Largest accumulator value that can still take a digit without wrapping.
  localparam logic [VALUE_W-1:0] TENTH_MAX = ALL_ONES / 10;
  localparam logic [DIGIT_W-1:0] LAST_DIGIT_AT_MAX = 4'd5;

  // Character codes.
  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

  // Queue between the front and the back part.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Character class as decided by the front part.
  typedef enum logic [2:0] {
    CLS_WS,
    CLS_PLUS,
    CLS_MINUS,
    CLS_DIGIT,
    CLS_NUL,
    CLS_OTHER
  } cls_t;

  // One classified character on its way to the back part.
  typedef struct packed {
    logic               start;
    cls_t               cls;
    logic [DIGIT_W-1:0] digit;
  } q_entry_t;

endpackage

### design/dsu_front.sv
module dsu_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_start_req,
  input  logic [7:0]        in_ch,
  output logic              push_o,
  output dsu_pkg::q_entry_t entry_o,
  input  logic              full_i
);
  import dsu_pkg::*;

  logic     vld_r;
  logic     vld_nxt;
  q_entry_t entry_r;
  q_entry_t entry_nxt;
  logic     in_acc;

  // Classify the incoming character.
  always_comb begin
    logic [CH_W-1:0] diff;
    diff = in_ch - CH_ZERO;
    entry_nxt.start = in_start_req;
    entry_nxt.digit = diff[DIGIT_W-1:0];
    priority if (in_ch == CH_NUL) begin
      entry_nxt.cls = CLS_NUL;
    end else if (in_ch == CH_SPACE || (in_ch >= CH_TAB && in_ch <= CH_CR)) begin
      entry_nxt.cls = CLS_WS;
    end else if (in_ch == CH_PLUS) begin
      entry_nxt.cls = CLS_PLUS;
    end else if (in_ch == CH_MINUS) begin
      entry_nxt.cls = CLS_MINUS;
    end else if (in_ch >= CH_ZERO && in_ch <= CH_NINE) begin
      entry_nxt.cls = CLS_DIGIT;
    end else begin
      entry_nxt.cls = CLS_OTHER;
    end
  end

  // The stage takes a request whenever it is empty or drains into the queue.
  assign in_ready = !vld_r || !full_i;
  assign in_acc   = in_valid && in_ready;
  assign push_o   = vld_r;
  assign entry_o  = entry_r;

  always_comb begin
    vld_nxt = vld_r;
    if (in_acc) begin
      vld_nxt = 1'b1;
    end else if (vld_r && !full_i) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      entry_r <= entry_nxt;
    end
  end

endmodule

### design/dsu_queue.sv
`include "decimal_string_to_u64_top_assert.svh"

module dsu_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_i,
  input  dsu_pkg::q_entry_t entry_i,
  output logic              full_o,
  output logic              valid_o,
  output dsu_pkg::q_entry_t entry_o,
  input  logic              pop_i
);
  import dsu_pkg::*;

  q_entry_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (count_r == QCNT_W'(QDEPTH));
  assign valid_o = (count_r != '0);
  assign entry_o = mem_r[rd_ptr_r];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= entry_i;
    end
  end

  // The fill count never passes the depth, and read and write pointers agree with it.
  `DSU_ASSERT_IMP(a_q_count_bound, clk, rst_n, 1'b1, count_r <= QCNT_W'(QDEPTH))
  `DSU_ASSERT_IMP(a_q_ptr_match, clk, rst_n, count_r == '0 || full_o, wr_ptr_r == rd_ptr_r)
  `DSU_ASSERT_NXT(a_q_push_seen, clk, rst_n, do_push && !do_pop, valid_o)

endmodule

### design/dsu_back.sv
`include "decimal_string_to_u64_top_assert.svh"

module dsu_back #(
  parameter int OFFSET_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid_i,
  input  dsu_pkg::q_entry_t      q_entry_i,
  output logic                   q_pop_o,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [63:0]            out_value,
  output logic [OFFSET_BITS-1:0] out_end_offset,
  output logic                   out_overflow,
  output logic                   out_digits_seen
);
  import dsu_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LEAD,
    PH_BODY
  } phase_t;

  phase_t                 phase_r;
  phase_t                 phase_nxt;
  logic [VALUE_W-1:0]     acc_r;
  logic [VALUE_W-1:0]     acc_nxt;
  logic                   neg_r;
  logic                   neg_nxt;
  logic                   ovf_r;
  logic                   ovf_nxt;
  logic                   dig_r;
  logic                   dig_nxt;
  logic [OFFSET_BITS-1:0] pos_r;
  logic [OFFSET_BITS-1:0] pos_nxt;

  logic                   out_valid_r;
  logic [VALUE_W-1:0]     out_value_r;
  logic [OFFSET_BITS-1:0] out_end_offset_r;
  logic                   out_overflow_r;
  logic                   out_digits_seen_r;

  logic                   emit;
  logic [VALUE_W-1:0]     res_value;
  logic [OFFSET_BITS-1:0] res_offset;

  // An entry is taken whenever the output register can hold a possible result.
  assign q_pop_o = q_valid_i && (!out_valid_r || out_ready);

  // Conversion step for one character.
  always_comb begin
    phase_t                 ph;
    logic [VALUE_W-1:0]     acc;
    logic                   neg;
    logic                   ovf;
    logic                   dig;
    logic [OFFSET_BITS-1:0] pos;
    logic [VALUE_W-1:0]     times_ten;
    logic                   step;

    ph  = q_entry_i.start ? PH_LEAD : phase_r;
    acc = q_entry_i.start ? '0 : acc_r;
    neg = q_entry_i.start ? 1'b0 : neg_r;
    ovf = q_entry_i.start ? 1'b0 : ovf_r;
    dig = q_entry_i.start ? 1'b0 : dig_r;
    pos = q_entry_i.start ? '0 : pos_r;

    // Multiply by ten as a shift-add, plus the new digit.
    times_ten = {acc[VALUE_W-4:0], 3'b000} + {acc[VALUE_W-2:0], 1'b0}
              + {{(VALUE_W-DIGIT_W){1'b0}}, q_entry_i.digit};

    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    ovf_nxt   = ovf_r;
    dig_nxt   = dig_r;
    pos_nxt   = pos_r;
    emit      = 1'b0;
    step      = 1'b0;

    if (q_pop_o) begin
      phase_nxt = ph;
      acc_nxt   = acc;
      neg_nxt   = neg;
      ovf_nxt   = ovf;
      dig_nxt   = dig;
      pos_nxt   = pos;
      if (ph != PH_IDLE) begin
        priority if (q_entry_i.cls == CLS_NUL) begin
          emit = 1'b1;
        end else if (ph == PH_LEAD && q_entry_i.cls == CLS_WS) begin
          step = 1'b1;
        end else if (ph == PH_LEAD && q_entry_i.cls == CLS_PLUS) begin
          phase_nxt = PH_BODY;
          step      = 1'b1;
        end else if (ph == PH_LEAD && q_entry_i.cls == CLS_MINUS) begin
          neg_nxt   = 1'b1;
          phase_nxt = PH_BODY;
          step      = 1'b1;
        end else if (q_entry_i.cls == CLS_DIGIT) begin
          if (acc < TENTH_MAX ||
              (acc == TENTH_MAX && q_entry_i.digit <= LAST_DIGIT_AT_MAX)) begin
            acc_nxt = times_ten;
          end else begin
            acc_nxt = ALL_ONES;
            ovf_nxt = 1'b1;
          end
          dig_nxt   = 1'b1;
          phase_nxt = PH_BODY;
          step      = 1'b1;
        end else begin
          emit = 1'b1;
        end
        if (emit) begin
          phase_nxt = PH_IDLE;
        end
        // Position saturates at its largest value.
        if (step && pos != {OFFSET_BITS{1'b1}}) begin
          pos_nxt = pos + 1'b1;
        end
      end
    end

    // Result fields as they stand when the string ends.
    if (ovf) begin
      res_value = ALL_ONES;
    end else if (neg) begin
      res_value = '0 - acc;
    end else begin
      res_value = acc;
    end
    res_offset = dig ? pos : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      acc_r       <= '0;
      neg_r       <= 1'b0;
      ovf_r       <= 1'b0;
      dig_r       <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      ovf_r   <= ovf_nxt;
      dig_r   <= dig_nxt;
      pos_r   <= pos_nxt;
      if (emit) begin
        out_valid_r       <= 1'b1;
        out_value_r       <= res_value;
        out_end_offset_r  <= res_offset;
        out_overflow_r    <= ovf_nxt;
        out_digits_seen_r <= dig_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign out_end_offset  = out_end_offset_r;
  assign out_overflow    = out_overflow_r;
  assign out_digits_seen = out_digits_seen_r;

  // Saturation and result consistency.
  `DSU_ASSERT_IMP(a_acc_saturated, clk, rst_n, ovf_r, acc_r == ALL_ONES)
  `DSU_ASSERT_IMP(a_ovf_value, clk, rst_n, out_valid_r && out_overflow_r,
    out_value_r == ALL_ONES && out_digits_seen_r)
  `DSU_ASSERT_IMP(a_no_digit_result, clk, rst_n, out_valid_r && !out_digits_seen_r,
    out_value_r == '0 && out_end_offset_r == '0 && !out_overflow_r)
  `DSU_ASSERT_NXT(a_idle_after_emit, clk, rst_n, emit, phase_r == PH_IDLE && out_valid_r)

endmodule

### design/decimal_string_to_u64_top.sv
// Streaming base-10 text to unsigned 64-bit converter, strtoull style. One
// character is taken per request; a request with in_start_req set begins a new
// string at offset 0. Leading whitespace (codes 9 to 13 and space) is skipped,
// one optional sign is taken, then digits are accumulated with saturation at
// all ones. A NUL or the first rejected character ends the string with one
// result (value, end offset, overflow and digits-seen flags); later characters
// are ignored until the next start. The block takes one character every cycle
// and sustains that rate as long as results are taken; each character is
// registered in the front register, then in the two-entry queue, from which
// the conversion step loads the result into the output register. The conversion
// step does one multiply-by-ten shift-add per cycle while the output register
// can take a result. OFFSET_BITS sets the width of the end offset, which
// saturates at its largest value.
module decimal_string_to_u64_top #(
  parameter int OFFSET_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_start_req,
  input  logic [7:0]             in_ch,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [63:0]            out_value,
  output logic [OFFSET_BITS-1:0] out_end_offset,
  output logic                   out_overflow,
  output logic                   out_digits_seen
);
  import dsu_pkg::*;

  logic     push;
  q_entry_t front_entry;
  logic     q_full;
  logic     q_valid;
  q_entry_t q_entry;
  logic     q_pop;

  // Front part: accept and classify characters.
  dsu_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_start_req (in_start_req),
    .in_ch        (in_ch),
    .push_o       (push),
    .entry_o      (front_entry),
    .full_i       (q_full)
  );

  // Short queue that decouples the two parts.
  dsu_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .entry_i (front_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (q_entry),
    .pop_i   (q_pop)
  );

  // Back part: conversion state and result register.
  dsu_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid_i       (q_valid),
    .q_entry_i       (q_entry),
    .q_pop_o         (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_value       (out_value),
    .out_end_offset  (out_end_offset),
    .out_overflow    (out_overflow),
    .out_digits_seen (out_digits_seen)
  );

endmodule

### bench/decimal_string_to_u64_checker.sv
module decimal_string_to_u64_checker #(
  parameter int OFFSET_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic                   in_start_req,
  input  logic [7:0]             in_ch,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [63:0]            out_value,
  input  logic [OFFSET_BITS-1:0] out_end_offset,
  input  logic                   out_overflow,
  input  logic                   out_digits_seen,
  output int                     fail_count,
  output int                     pending
);

  import dsu_pkg::*;

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_LEAD,
    SCAN_BODY
  } scan_phase_t;

  typedef struct packed {
    logic [VALUE_W-1:0]     value;
    logic [OFFSET_BITS-1:0] end_offset;
    logic                   overflow;
    logic                   digits_seen;
  } conversion_t;

  // Conversions predicted from accepted requests, oldest first.
  conversion_t expected_conversions[$];

  // Shadow copy of the scanner state.
  scan_phase_t            scan_phase = SCAN_IDLE;
  logic [VALUE_W-1:0]     magnitude  = '0;
  logic                   minus_seen = 1'b0;
  logic                   range_error = 1'b0;
  logic                   digit_seen = 1'b0;
  logic [OFFSET_BITS-1:0] char_index = '0;
  int                     mismatches = 0;

  // Advance the shadow scanner by one character and queue a conversion when
  // the string ends.
  task automatic scan_char(input logic start, input logic [7:0] c);
    conversion_t        conv;
    logic [DIGIT_W-1:0] d;
    logic               lead;
    logic               stop;
    if (start) begin
      scan_phase  = SCAN_LEAD;
      magnitude   = '0;
      minus_seen  = 1'b0;
      range_error = 1'b0;
      digit_seen  = 1'b0;
      char_index  = '0;
    end
    if (scan_phase == SCAN_IDLE) return;
    lead = (scan_phase == SCAN_LEAD);
    stop = 1'b0;
    if (c == CH_NUL) begin
      stop = 1'b1;
    end else if (lead && (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
      // Leading whitespace is skipped.
    end else if (lead && c == CH_PLUS) begin
      scan_phase = SCAN_BODY;
    end else if (lead && c == CH_MINUS) begin
      minus_seen = 1'b1;
      scan_phase = SCAN_BODY;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      d = DIGIT_W'(c - CH_ZERO);
      if (magnitude < TENTH_MAX ||
          (magnitude == TENTH_MAX && d <= LAST_DIGIT_AT_MAX)) begin
        magnitude = magnitude * 10 + VALUE_W'(d);
      end else begin
        magnitude   = ALL_ONES;
        range_error = 1'b1;
      end
      digit_seen = 1'b1;
      scan_phase = SCAN_BODY;
    end else begin
      stop = 1'b1;
    end

    if (stop) begin
      if (range_error) begin
        conv.value = ALL_ONES;
      end else if (minus_seen) begin
        conv.value = VALUE_W'(0) - magnitude;
      end else begin
        conv.value = magnitude;
      end
      conv.end_offset  = digit_seen ? char_index : '0;
      conv.overflow    = range_error;
      conv.digits_seen = digit_seen;
      expected_conversions.push_back(conv);
      scan_phase = SCAN_IDLE;
    end else if (char_index != {OFFSET_BITS{1'b1}}) begin
      char_index = char_index + 1'b1;
    end
  endtask

  // Compare one delivered result against the oldest prediction.
  task automatic check_conversion();
    conversion_t exp_c;
    if (expected_conversions.size() == 0) begin
      $error("unexpected result: value %h, end_offset %0d", out_value, out_end_offset);
      mismatches++;
    end else begin
      exp_c = expected_conversions.pop_front();
      if (out_value !== exp_c.value) begin
        $error("value: expected %h, actual %h", exp_c.value, out_value);
        mismatches++;
      end
      if (out_end_offset !== exp_c.end_offset) begin
        $error("end_offset: expected %0d, actual %0d", exp_c.end_offset, out_end_offset);
        mismatches++;
      end
      if (out_overflow !== exp_c.overflow) begin
        $error("overflow: expected %b, actual %b", exp_c.overflow, out_overflow);
        mismatches++;
      end
      if (out_digits_seen !== exp_c.digits_seen) begin
        $error("digits_seen: expected %b, actual %b", exp_c.digits_seen, out_digits_seen);
        mismatches++;
      end
    end
  endtask

  // Watch both channels at the rising edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      scan_phase  = SCAN_IDLE;
      magnitude   = '0;
      minus_seen  = 1'b0;
      range_error = 1'b0;
      digit_seen  = 1'b0;
      char_index  = '0;
      expected_conversions.delete();
    end else begin
      if (out_valid && out_ready) check_conversion();
      if (in_valid && in_ready) scan_char(in_start_req, in_ch);
    end
    fail_count <= mismatches;
    pending    <= expected_conversions.size();
  end

endmodule

### bench/tb.sv
module tb;

  import dsu_pkg::*;

  localparam int OFFSET_BITS  = 16;
  localparam int RANDOM_ITEMS = 1450;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 600000;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic                   in_start_req;
  logic [7:0]             in_ch;
  logic                   out_valid;
  logic                   out_ready;
  logic [63:0]            out_value;
  logic [OFFSET_BITS-1:0] out_end_offset;
  logic                   out_overflow;
  logic                   out_digits_seen;

  int   fail_count;
  int   pending_results;
  int   send_pct = 0;
  int   recv_pct = 0;
  int   items_sent = 0;
  int   cycle_count = 0;
  logic fresh_string = 1'b0;
  logic pressure_on = 1'b0;
  logic pressure_done = 1'b0;

  decimal_string_to_u64_top #(
    .OFFSET_BITS(OFFSET_BITS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_start_req   (in_start_req),
    .in_ch          (in_ch),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value      (out_value),
    .out_end_offset (out_end_offset),
    .out_overflow   (out_overflow),
    .out_digits_seen(out_digits_seen)
  );

  decimal_string_to_u64_checker #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_conv_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_start_req   (in_start_req),
    .in_ch          (in_ch),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value      (out_value),
    .out_end_offset (out_end_offset),
    .out_overflow   (out_overflow),
    .out_digits_seen(out_digits_seen),
    .fail_count     (fail_count),
    .pending        (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off when asked for.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (pressure_on && !pressure_done) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        pressure_done = 1'b1;
      end else begin
        out_ready = ($urandom_range(0, 99) >= recv_pct);
      end
    end
  end

  // Offer one request after a random gap and wait until it is taken.
  task automatic send_char(input logic start, input logic [7:0] c);
    while ($urandom_range(0, 99) < send_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid     = 1'b1;
    in_start_req = start;
    in_ch        = c;
    do @(posedge clk); while (!in_ready);
  endtask

  // Next character of the current string; the first one carries the start flag.
  task automatic put_char(input logic [7:0] c);
    send_char(fresh_string, c);
    fresh_string = 1'b0;
    items_sent++;
  endtask

  task automatic send_text(input string txt, input logic [7:0] stop_ch);
    fresh_string = 1'b1;
    foreach (txt[i]) put_char(txt[i]);
    put_char(stop_ch);
  endtask

  function automatic logic [7:0] blank_char();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? CH_SPACE : CH_TAB + 8'(k);
  endfunction

  function automatic logic [7:0] digit_char();
    return 8'(CH_ZERO + $urandom_range(0, 9));
  endfunction

  // One random string: mostly well formed, some noise and broken endings.
  task automatic send_random_string();
    int    roll;
    int    n;
    string prefix;
    roll = $urandom_range(0, 99);
    fresh_string = 1'b1;
    if (roll < 15) begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        fresh_string = 1'($urandom_range(0, 1));
        put_char(8'($urandom_range(0, 255)));
      end
    end else begin
      repeat ($urandom_range(0, 2)) put_char(blank_char());
      case ($urandom_range(0, 3))
        0: put_char(CH_PLUS);
        1: put_char(CH_MINUS);
        default: begin
        end
      endcase
      if ($urandom_range(0, 4) == 0) begin
        // Near the saturation point the following digits decide overflow.
        prefix = "1844674407370955161";
        foreach (prefix[i]) put_char(prefix[i]);
        repeat ($urandom_range(1, 2)) put_char(digit_char());
      end else begin
        repeat ($urandom_range(0, 9)) put_char(digit_char());
      end
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        put_char(CH_NUL);
      end else if (roll < 65) begin
        // Left open; the next start restarts the conversion.
      end else if (roll < 80) begin
        put_char(($urandom_range(0, 1) == 0) ? blank_char() : CH_MINUS);
      end else begin
        put_char(8'($urandom_range(0, 255)));
      end
      // A trailing byte may follow; the block ignores it once the string has ended.
      if ($urandom_range(0, 3) == 0) send_char(1'b0, 8'($urandom_range(0, 255)));
    end
  endtask

  // Main stimulus and verdict.
  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_start_req = 1'b0;
    in_ch        = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Characters without a start while idle produce nothing.
    send_char(1'b0, "x");
    send_char(1'b0, 8'hFF);

    // Directed strings around the edges of the format.
    send_text("18446744073709551615", CH_NUL);
    send_text("18446744073709551616", CH_NUL);
    send_text("-1", CH_NUL);
    fresh_string = 1'b1;
    for (int k = CH_TAB; k <= CH_CR; k++) put_char(8'(k));
    put_char(CH_SPACE);
    put_char(CH_PLUS);
    put_char(CH_ZERO);
    put_char(8'hFF);
    send_text("+-5", CH_NUL);
    send_text("-", CH_NUL);
    send_text("12 3", CH_NUL);
    send_text("99999999999999999999999", CH_NUL);
    send_text("", 8'h08);
    send_text("", CH_NUL);
    send_text("-0", "/");
    send_text("9", ":");
    // A start in the middle of a string restarts the conversion.
    fresh_string = 1'b1;
    put_char("4");
    put_char("5");
    send_text("6", CH_NUL);

    // Random strings in several idling phases.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_pct = 0;
          recv_pct = 0;
        end
        1: begin
          send_pct = 55;
          recv_pct = 0;
        end
        2: begin
          send_pct = 0;
          recv_pct = 55;
        end
        default: begin
          send_pct = 7;
          recv_pct = 7;
        end
      endcase
      while (items_sent < (ph + 1) * RANDOM_ITEMS / 4) send_random_string();
      if (ph == 0) begin
        // Keep offering short strings while the result side holds off.
        pressure_on = 1'b1;
        repeat (40) send_text("5", CH_NUL);
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
